// ===== sv/ccw_pkg.sv =====
// Shared types and constants for the character display cursor writer.
`default_nettype none

package ccw_pkg;

   localparam int ROW_COUNT_DEFAULT = 4;
   localparam int ROW_SLOTS         = 4;
   localparam int QUEUE_DEPTH       = 2;

   localparam int COL_W   = 6;
   localparam int ROW_W   = 2;
   localparam int BASE_W  = 7;
   localparam int BYTE_W  = 8;
   localparam int FLAGS_W = 3;
   localparam int WAIT_W  = 2;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 7;

   localparam logic [CSR_IDX_W-1:0] CSR_COLUMNS   = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_ROW0_BASE = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_ROW1_BASE = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_ROW2_BASE = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_ROW3_BASE = 3'd4;

   localparam logic [COL_W-1:0]  COLUMNS_RESET   = 6'd20;
   localparam logic [BASE_W-1:0] ROW0_BASE_RESET = 7'h00;
   localparam logic [BASE_W-1:0] ROW1_BASE_RESET = 7'h40;
   localparam logic [BASE_W-1:0] ROW2_BASE_RESET = 7'h14;
   localparam logic [BASE_W-1:0] ROW3_BASE_RESET = 7'h54;

   localparam logic [1:0] REQ_TEXT    = 2'd0;
   localparam logic [1:0] REQ_COMMAND = 2'd1;
   localparam logic [1:0] REQ_SET_POS = 2'd2;

   localparam logic [BYTE_W-1:0] CHAR_NEWLINE     = 8'h0A;
   localparam logic [BYTE_W-1:0] CMD_CLEAR        = 8'h01;
   localparam logic [BYTE_W-1:0] CMD_HOME         = 8'h02;
   localparam logic [BYTE_W-1:0] CMD_SET_ADDR     = 8'h80;
   localparam logic [BYTE_W-1:0] CMD_DISP_MASK    = 8'hF8;
   localparam logic [BYTE_W-1:0] CMD_DISP_CTRL    = 8'h08;
   localparam logic [WAIT_W-1:0] CLEAR_WAIT_MS    = 2'd2;

   localparam logic RS_COMMAND = 1'b0;
   localparam logic RS_DATA    = 1'b1;

   typedef struct packed {
      logic               two_bytes;
      logic               rs0;
      logic [BYTE_W-1:0]  byte0;
      logic [WAIT_W-1:0]  wait0;
      logic [BYTE_W-1:0]  byte1;
      logic [COL_W-1:0]   pos_col;
      logic [ROW_W-1:0]   pos_row;
      logic [FLAGS_W-1:0] flags;
   } job_type;

endpackage

`default_nettype wire

// ===== sv/ccw_front.sv =====
// Front end: configuration registers, cursor tracking and byte job building.
`default_nettype none

module ccw_front import ccw_pkg::*; #(
   parameter int ROW_COUNT = ROW_COUNT_DEFAULT
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  csr_write,
   input  wire logic [CSR_IDX_W-1:0]  csr_index,
   input  wire logic [CSR_DATA_W-1:0] csr_wdata,
   input  wire logic                  accept,
   input  wire logic [1:0]            req_type,
   input  wire logic [BYTE_W-1:0]     req_byte_value,
   input  wire logic                  req_end_of_text,
   input  wire logic [COL_W-1:0]      req_target_col,
   input  wire logic [2:0]            req_target_row,
   output logic                       job_push,
   output job_type                    job
);

   logic [COL_W-1:0]  columns_ff;
   logic [BASE_W-1:0] base_ff [ROW_SLOTS];
   logic [COL_W-1:0]  col_ff, col_in;
   logic [ROW_W-1:0]  row_ff, row_in;
   logic              halted_ff, halted_in;
   logic              disp_on_ff, disp_on_in;
   logic              shown_ff, shown_in;
   logic              blink_ff, blink_in;

   logic [2:0]        row_next;
   logic              last_row;
   logic              cols_nz;
   logic [BYTE_W-1:0] wrap_cmd;
   logic [BASE_W-1:0] addr;
   logic              addr_hit;
   logic [ROW_W-1:0]  hit_row;
   logic [BASE_W-1:0] hit_off;
   logic [BASE_W-1:0] set_addr;
   logic              set_valid;
   logic              emit;

   always_comb begin
      row_next = {1'b0, row_ff} + 3'd1;
      last_row = row_next >= 3'(ROW_COUNT);
      cols_nz  = columns_ff != '0;
      wrap_cmd = CMD_SET_ADDR | {1'b0, base_ff[row_next[1:0]]};
      addr     = req_byte_value[BASE_W-1:0];
      set_addr = base_ff[req_target_row[1:0]] + {1'b0, req_target_col};
      set_valid = (req_target_col < columns_ff) && (req_target_row < 3'(ROW_COUNT));

      addr_hit = 1'b0;
      hit_row  = '0;
      hit_off  = '0;
      for (int r = ROW_COUNT - 1; r >= 0; r--) begin
         if ((addr >= base_ff[2'(r)]) &&
             ({1'b0, addr} < ({1'b0, base_ff[2'(r)]} + {2'b00, columns_ff}))) begin
            addr_hit = 1'b1;
            hit_row  = 2'(r);
            hit_off  = addr - base_ff[2'(r)];
         end
      end

      col_in     = col_ff;
      row_in     = row_ff;
      halted_in  = halted_ff;
      disp_on_in = disp_on_ff;
      shown_in   = shown_ff;
      blink_in   = blink_ff;
      emit       = 1'b0;
      job.two_bytes = 1'b0;
      job.rs0       = RS_COMMAND;
      job.byte0     = req_byte_value;
      job.wait0     = '0;
      job.byte1     = req_byte_value;

      case (req_type)
         REQ_TEXT: begin
            if (!halted_ff) begin
               if (req_byte_value == CHAR_NEWLINE || col_ff >= columns_ff) begin
                  if (last_row) begin
                     halted_in = 1'b1;
                  end else if (cols_nz) begin
                     emit          = 1'b1;
                     job.byte0     = wrap_cmd;
                     row_in        = row_next[1:0];
                     if (req_byte_value == CHAR_NEWLINE) begin
                        col_in = '0;
                     end else begin
                        job.two_bytes = 1'b1;
                        col_in        = 6'd1;
                     end
                  end
               end else begin
                  emit    = 1'b1;
                  job.rs0 = RS_DATA;
                  col_in  = col_ff + 6'd1;
               end
            end
            if (req_end_of_text) begin
               halted_in = 1'b0;
            end
         end
         REQ_COMMAND: begin
            emit = 1'b1;
            if (req_byte_value == CMD_CLEAR || req_byte_value == CMD_HOME) begin
               job.wait0 = CLEAR_WAIT_MS;
               col_in    = '0;
               row_in    = '0;
            end else if (req_byte_value[BYTE_W-1]) begin
               if (addr_hit) begin
                  row_in = hit_row;
                  col_in = hit_off[COL_W-1:0];
               end
            end else if ((req_byte_value & CMD_DISP_MASK) == CMD_DISP_CTRL) begin
               disp_on_in = req_byte_value[2];
               shown_in   = req_byte_value[1];
               blink_in   = req_byte_value[0];
            end
         end
         REQ_SET_POS: begin
            if (set_valid) begin
               emit      = 1'b1;
               job.byte0 = CMD_SET_ADDR | {1'b0, set_addr};
               col_in    = req_target_col;
               row_in    = req_target_row[1:0];
            end
         end
         default: begin
         end
      endcase

      job.pos_col = col_in;
      job.pos_row = row_in;
      job.flags   = {disp_on_in, shown_in, blink_in};
      job_push    = accept && emit;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         columns_ff <= COLUMNS_RESET;
         base_ff[0] <= ROW0_BASE_RESET;
         base_ff[1] <= ROW1_BASE_RESET;
         base_ff[2] <= ROW2_BASE_RESET;
         base_ff[3] <= ROW3_BASE_RESET;
         col_ff     <= '0;
         row_ff     <= '0;
         halted_ff  <= 1'b0;
         disp_on_ff <= 1'b1;
         shown_ff   <= 1'b0;
         blink_ff   <= 1'b0;
      end else begin
         if (csr_write) begin
            case (csr_index)
               CSR_COLUMNS:   columns_ff <= csr_wdata[COL_W-1:0];
               CSR_ROW0_BASE: base_ff[0] <= csr_wdata;
               CSR_ROW1_BASE: base_ff[1] <= csr_wdata;
               CSR_ROW2_BASE: base_ff[2] <= csr_wdata;
               CSR_ROW3_BASE: base_ff[3] <= csr_wdata;
               default: begin
               end
            endcase
         end
         if (accept) begin
            col_ff     <= col_in;
            row_ff     <= row_in;
            halted_ff  <= halted_in;
            disp_on_ff <= disp_on_in;
            shown_ff   <= shown_in;
            blink_ff   <= blink_in;
         end
      end
   end

endmodule

`default_nettype wire

// ===== sv/ccw_queue.sv =====
// Short job queue between the front end and the nibble sender.
`default_nettype none

module ccw_queue import ccw_pkg::*; (
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    push,
   input  wire job_type push_job,
   input  wire logic    pop,
   output logic         full,
   output logic         head_valid,
   output job_type      head_job
);

   localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

   job_type            slot_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0]   wr_ptr_ff, rd_ptr_ff;
   logic [CNT_W-1:0]   count_ff;

   assign full       = count_ff == CNT_W'(QUEUE_DEPTH);
   assign head_valid = count_ff != '0;
   assign head_job   = slot_ff[rd_ptr_ff];

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push) begin
            wr_ptr_ff <= (wr_ptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
         end
         if (pop) begin
            rd_ptr_ff <= (rd_ptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
         end
         if (push && !pop) begin
            count_ff <= count_ff + 1'b1;
         end else if (pop && !push) begin
            count_ff <= count_ff - 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_job;
      end
   end

endmodule

`default_nettype wire

// ===== sv/ccw_back.sv =====
// Back end: splits each queued job into nibbles behind an output register.
`default_nettype none

module ccw_back import ccw_pkg::*; (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        head_valid,
   input  wire job_type     head_job,
   output logic             head_pop,
   input  wire logic        rsp_pop,
   output logic             rsp_empty,
   output logic             rsp_register_select,
   output logic [3:0]       rsp_nibble,
   output logic [WAIT_W-1:0] rsp_extra_wait_ms,
   output logic             rsp_last,
   output logic [COL_W-1:0] rsp_pos_col,
   output logic [ROW_W-1:0] rsp_pos_row,
   output logic [FLAGS_W-1:0] rsp_display_flags
);

   logic [1:0]         idx_ff;
   logic               valid_ff;
   logic               load;
   logic               is_last;
   logic [3:0]         nib_in;
   logic               rs_in;
   logic [WAIT_W-1:0]  wait_in;

   always_comb begin
      load    = head_valid && (!valid_ff || rsp_pop);
      is_last = (idx_ff == 2'd1 && !head_job.two_bytes) || idx_ff == 2'd3;
      rs_in   = idx_ff[1] ? RS_DATA : head_job.rs0;
      wait_in = (idx_ff == 2'd1) ? head_job.wait0 : '0;
      case (idx_ff)
         2'd0:    nib_in = head_job.byte0[7:4];
         2'd1:    nib_in = head_job.byte0[3:0];
         2'd2:    nib_in = head_job.byte1[7:4];
         default: nib_in = head_job.byte1[3:0];
      endcase
      head_pop  = load && is_last;
      rsp_empty = !valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff   <= '0;
         valid_ff <= 1'b0;
      end else begin
         if (load) begin
            idx_ff   <= is_last ? 2'd0 : idx_ff + 2'd1;
            valid_ff <= 1'b1;
         end else if (rsp_pop) begin
            valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         rsp_register_select <= rs_in;
         rsp_nibble          <= nib_in;
         rsp_extra_wait_ms   <= wait_in;
         rsp_last            <= is_last;
         rsp_pos_col         <= head_job.pos_col;
         rsp_pos_row         <= head_job.pos_row;
         rsp_display_flags   <= head_job.flags;
      end
   end

endmodule

`default_nettype wire

// ===== sv/char_lcd_cursor_writer.sv =====
// Top level of the character display cursor writer over a 4-bit bus.
//
//   port group  direction  handshake         contents
//   req_        in         req_push/req_full one request word
//   rsp_        out        rsp_empty/rsp_pop one nibble word
//   csr_        in         csr_write         register index and data
//
// The front end takes one request word per cycle while its two-entry job queue has room.
// The sender emits one nibble word per cycle while rsp_pop takes them, so each job yields
// two or four nibble words and a request that sends nothing is still taken at the request side.
// Reset is synchronous; a stalled rsp_ side fills the queue and then raises req_full.
`default_nettype none

module char_lcd_cursor_writer import ccw_pkg::*; #(
   parameter int ROW_COUNT = ROW_COUNT_DEFAULT
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_push,
   output logic                       req_full,
   input  wire logic [1:0]            req_type,
   input  wire logic [BYTE_W-1:0]     req_byte_value,
   input  wire logic                  req_end_of_text,
   input  wire logic [COL_W-1:0]      req_target_col,
   input  wire logic [2:0]            req_target_row,
   output logic                       rsp_empty,
   input  wire logic                  rsp_pop,
   output logic                       rsp_register_select,
   output logic [3:0]                 rsp_nibble,
   output logic [WAIT_W-1:0]          rsp_extra_wait_ms,
   output logic                       rsp_last,
   output logic [COL_W-1:0]           rsp_pos_col,
   output logic [ROW_W-1:0]           rsp_pos_row,
   output logic [FLAGS_W-1:0]         rsp_display_flags,
   input  wire logic                  csr_write,
   input  wire logic [CSR_IDX_W-1:0]  csr_index,
   input  wire logic [CSR_DATA_W-1:0] csr_wdata
);

   logic    accept;
   logic    job_push;
   job_type job;
   logic    head_valid;
   job_type head_job;
   logic    head_pop;

   assign accept = req_push && !req_full;

   ccw_front #(
      .ROW_COUNT(ROW_COUNT)
   ) u_front (
      .clock           (clock),
      .reset           (reset),
      .csr_write       (csr_write),
      .csr_index       (csr_index),
      .csr_wdata       (csr_wdata),
      .accept          (accept),
      .req_type        (req_type),
      .req_byte_value  (req_byte_value),
      .req_end_of_text (req_end_of_text),
      .req_target_col  (req_target_col),
      .req_target_row  (req_target_row),
      .job_push        (job_push),
      .job             (job)
   );

   ccw_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (job_push),
      .push_job   (job),
      .pop        (head_pop),
      .full       (req_full),
      .head_valid (head_valid),
      .head_job   (head_job)
   );

   ccw_back u_back (
      .clock               (clock),
      .reset               (reset),
      .head_valid          (head_valid),
      .head_job            (head_job),
      .head_pop            (head_pop),
      .rsp_pop             (rsp_pop),
      .rsp_empty           (rsp_empty),
      .rsp_register_select (rsp_register_select),
      .rsp_nibble          (rsp_nibble),
      .rsp_extra_wait_ms   (rsp_extra_wait_ms),
      .rsp_last            (rsp_last),
      .rsp_pos_col         (rsp_pos_col),
      .rsp_pos_row         (rsp_pos_row),
      .rsp_display_flags   (rsp_display_flags)
   );

endmodule

`default_nettype wire

// ===== sv/ccw_checker.sv =====
// Port-level checker for the cursor writer, bound to the top level.
`default_nettype none

module ccw_checker import ccw_pkg::*; #(
   parameter int ROW_COUNT = ROW_COUNT_DEFAULT
) (
   input wire logic               clock,
   input wire logic               reset,
   input wire logic               req_full,
   input wire logic               rsp_empty,
   input wire logic               rsp_pop,
   input wire logic               rsp_register_select,
   input wire logic [3:0]         rsp_nibble,
   input wire logic [WAIT_W-1:0]  rsp_extra_wait_ms,
   input wire logic               rsp_last,
   input wire logic [ROW_W-1:0]   rsp_pos_row
);

   a_reset_empty: assert property (@(posedge clock) reset |=> rsp_empty && !req_full)
      else $error("Queue not empty after reset.");

   a_wait_on_last_cmd: assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && rsp_extra_wait_ms != '0) |->
      (rsp_register_select == RS_COMMAND && rsp_last && rsp_extra_wait_ms == CLEAR_WAIT_MS))
      else $error("Extra wait on a word that is not the last command nibble.");

   a_row_in_range: assert property (@(posedge clock) disable iff (reset)
      !rsp_empty |-> ({1'b0, rsp_pos_row} < 3'(ROW_COUNT)))
      else $error("Reported row beyond the configured row count.");

   a_stall_holds: assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && !rsp_pop) |=>
      (!rsp_empty && $stable(rsp_nibble) && $stable(rsp_last)))
      else $error("Result word changed while stalled.");

endmodule

bind char_lcd_cursor_writer ccw_checker #(.ROW_COUNT(ROW_COUNT)) u_checker (.*);

`default_nettype wire
